### rtl/core/rtop_pkg.sv
// ----------------------------------------------------------------------------
// rtop_pkg
// Shared types, widths, codes and constant tables of the relative time
// offset parser.
// ----------------------------------------------------------------------------
package rtop_pkg;

  localparam int INT_BITS    = 24;  // integer accumulator width
  localparam int FRAC_DIGITS = 6;   // fraction digits kept
  localparam int FRAC_BITS   = 8;   // fractional bits of the result

  localparam int CHAR_W   = 8;
  localparam int NOW_W    = 40;
  localparam int VAL_W    = 58;
  localparam int FACC_W   = 20;     // holds 10^FRAC_DIGITS - 1
  localparam int FDIG_W   = 3;
  localparam int UNIT_W   = 3;
  localparam int SCALE_W  = 25;     // holds 86400 * 365
  localparam int PROD_W   = INT_BITS + SCALE_W;
  localparam int DIVD_W   = 54;     // scaled fraction << FRAC_BITS plus half
  localparam int DIVS_W   = 20;     // holds 10^FRAC_DIGITS
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT    = 2'd2;

  // Result kind codes
  localparam logic [KIND_W-1:0] KIND_NOW   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EPOCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REL   = 2'd2;

  // Job class chosen by the front end
  localparam logic [1:0] OP_NOW   = 2'd0;
  localparam logic [1:0] OP_ERR   = 2'd1;
  localparam logic [1:0] OP_EPOCH = 2'd2;
  localparam logic [1:0] OP_REL   = 2'd3;

  // Unit codes
  localparam logic [UNIT_W-1:0] UNIT_S = 3'd0;
  localparam logic [UNIT_W-1:0] UNIT_MIN = 3'd1;
  localparam logic [UNIT_W-1:0] UNIT_H = 3'd2;
  localparam logic [UNIT_W-1:0] UNIT_D = 3'd3;
  localparam logic [UNIT_W-1:0] UNIT_MON = 3'd4;
  localparam logic [UNIT_W-1:0] UNIT_Y = 3'd5;

  typedef struct packed {
    logic [1:0]          op;
    logic                minus;
    logic                overflow;
    logic [INT_BITS-1:0] int_acc;
    logic [FACC_W-1:0]   frac_acc;
    logic [FDIG_W-1:0]   frac_digits;
    logic [UNIT_W-1:0]   unit;
    logic [NOW_W-1:0]    now;
  } job_t;

  function automatic logic [SCALE_W-1:0] unit_scale(input logic [UNIT_W-1:0] u);
    logic [SCALE_W-1:0] s;
    case (u)
      UNIT_S:   s = 25'd1;
      UNIT_MIN: s = 25'd60;
      UNIT_H:   s = 25'd3600;
      UNIT_D:   s = 25'd86400;
      UNIT_MON: s = 25'd2592000;
      UNIT_Y:   s = 25'd31536000;
      default:  s = 25'd1;
    endcase
    return s;
  endfunction

  function automatic logic [DIVS_W-1:0] pow10(input logic [FDIG_W-1:0] n);
    logic [DIVS_W-1:0] p;
    case (n)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/rtop_front.sv
// ----------------------------------------------------------------------------
// rtop_front
// Takes one character per transaction, tracks the parse state and, on the
// end transaction, classifies the string and pushes one job.
// ----------------------------------------------------------------------------
module rtop_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rtop_pkg::CHAR_W-1:0]    char_code,
  input  logic                           is_end,
  input  logic [rtop_pkg::NOW_W-1:0]     now_seconds,
  input  logic                           q_full,
  output logic                           push,
  output rtop_pkg::job_t                 push_job
);

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_SIGN = 2'd1;
  localparam logic [1:0] PH_NUM  = 2'd2;
  localparam logic [1:0] PH_UNIT = 2'd3;

  localparam logic [1:0] SG_NONE  = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_MINUS = 2'd2;

  localparam logic [2:0] NM_FULL = 3'd3;
  localparam logic [2:0] NM_FAIL = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_BIGM  = 8'h4D;
  localparam logic [7:0] CH_Y     = 8'h79;

  localparam logic [rtop_pkg::INT_BITS+3:0] INT_LIM =
    {4'b0, {rtop_pkg::INT_BITS{1'b1}}};

  logic [1:0]                        phase, phase_next;
  logic [1:0]                        sign_mode, sign_mode_next;
  logic                              in_fraction, in_fraction_next;
  logic [rtop_pkg::INT_BITS-1:0]     integer_acc, integer_acc_next;
  logic [rtop_pkg::FACC_W-1:0]       fraction_acc, fraction_acc_next;
  logic [rtop_pkg::FDIG_W-1:0]       fraction_digits, fraction_digits_next;
  logic [rtop_pkg::UNIT_W-1:0]       unit_code, unit_code_next;
  logic [2:0]                        now_match, now_match_next;
  logic                              error_flag, error_flag_next;
  logic                              overflow_flag, overflow_flag_next;

  logic                              accept;
  logic                              is_space, is_digit, is_sign, is_unit;
  logic [3:0]                        digit;
  logic [rtop_pkg::UNIT_W-1:0]       unit_val;
  logic [7:0]                        word_char;
  logic [rtop_pkg::INT_BITS+3:0]     int_prod;
  logic [rtop_pkg::FACC_W+3:0]       frac_prod;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign is_space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
  assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
  assign digit    = char_code[3:0];

  assign int_prod  = {4'b0, integer_acc} * (rtop_pkg::INT_BITS+4)'(10)
                     + {{rtop_pkg::INT_BITS{1'b0}}, digit};
  assign frac_prod = {4'b0, fraction_acc} * (rtop_pkg::FACC_W+4)'(10)
                     + {{rtop_pkg::FACC_W{1'b0}}, digit};

  always_comb begin
    is_unit  = 1'b1;
    unit_val = rtop_pkg::UNIT_S;
    case (char_code)
      CH_S:    unit_val = rtop_pkg::UNIT_S;
      CH_M:    unit_val = rtop_pkg::UNIT_MIN;
      CH_H:    unit_val = rtop_pkg::UNIT_H;
      CH_D:    unit_val = rtop_pkg::UNIT_D;
      CH_BIGM: unit_val = rtop_pkg::UNIT_MON;
      CH_Y:    unit_val = rtop_pkg::UNIT_Y;
      default: is_unit  = 1'b0;
    endcase
  end

  always_comb begin
    case (now_match)
      3'd0:    word_char = CH_N;
      3'd1:    word_char = CH_O;
      default: word_char = CH_W;
    endcase
  end

  // Next parse state for one character
  always_comb begin
    phase_next           = phase;
    sign_mode_next       = sign_mode;
    in_fraction_next     = in_fraction;
    integer_acc_next     = integer_acc;
    fraction_acc_next    = fraction_acc;
    fraction_digits_next = fraction_digits;
    unit_code_next       = unit_code;
    error_flag_next      = error_flag;
    overflow_flag_next   = overflow_flag;

    if (now_match < NM_FULL && char_code == word_char) begin
      now_match_next = now_match + 3'd1;
    end else begin
      now_match_next = NM_FAIL;
    end

    if (!error_flag) begin
      if (is_space) begin
        if (phase != PH_NONE) error_flag_next = 1'b1;
      end else if (is_sign) begin
        if (phase != PH_NONE) begin
          error_flag_next = 1'b1;
        end else begin
          phase_next     = PH_SIGN;
          sign_mode_next = (char_code == CH_PLUS) ? SG_PLUS : SG_MINUS;
        end
      end else if (is_digit) begin
        if (phase == PH_UNIT) begin
          error_flag_next = 1'b1;
        end else begin
          phase_next = PH_NUM;
          if (!in_fraction) begin
            if (int_prod > INT_LIM) begin
              integer_acc_next   = {rtop_pkg::INT_BITS{1'b1}};
              overflow_flag_next = 1'b1;
            end else begin
              integer_acc_next = int_prod[rtop_pkg::INT_BITS-1:0];
            end
          end else if (fraction_digits < rtop_pkg::FDIG_W'(rtop_pkg::FRAC_DIGITS)) begin
            fraction_acc_next    = frac_prod[rtop_pkg::FACC_W-1:0];
            fraction_digits_next = fraction_digits + 3'd1;
          end
        end
      end else if (char_code == CH_DOT) begin
        if (phase == PH_UNIT || in_fraction) begin
          error_flag_next = 1'b1;
        end else begin
          phase_next       = PH_NUM;
          in_fraction_next = 1'b1;
        end
      end else if (is_unit) begin
        if (phase == PH_UNIT) begin
          error_flag_next = 1'b1;
        end else begin
          phase_next     = PH_UNIT;
          unit_code_next = unit_val;
        end
      end else begin
        error_flag_next = 1'b1;
      end
    end
  end

  // Classify on the end transaction
  assign push = accept && is_end;

  always_comb begin
    push_job.minus       = (sign_mode == SG_MINUS);
    push_job.overflow    = overflow_flag;
    push_job.int_acc     = integer_acc;
    push_job.frac_acc    = fraction_acc;
    push_job.frac_digits = fraction_digits;
    push_job.unit        = unit_code;
    push_job.now         = now_seconds;
    if (now_match == NM_FULL) begin
      push_job.op = rtop_pkg::OP_NOW;
    end else if (error_flag || phase == PH_NONE || phase == PH_SIGN) begin
      push_job.op = rtop_pkg::OP_ERR;
    end else if (phase == PH_NUM && sign_mode == SG_NONE) begin
      push_job.op = rtop_pkg::OP_EPOCH;
    end else begin
      push_job.op = rtop_pkg::OP_REL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase           <= PH_NONE;
      sign_mode       <= SG_NONE;
      in_fraction     <= 1'b0;
      integer_acc     <= '0;
      fraction_acc    <= '0;
      fraction_digits <= '0;
      unit_code       <= rtop_pkg::UNIT_S;
      now_match       <= 3'd0;
      error_flag      <= 1'b0;
      overflow_flag   <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      sign_mode       <= sign_mode_next;
      in_fraction     <= in_fraction_next;
      integer_acc     <= integer_acc_next;
      fraction_acc    <= fraction_acc_next;
      fraction_digits <= fraction_digits_next;
      unit_code       <= unit_code_next;
      now_match       <= now_match_next;
      error_flag      <= error_flag_next;
      overflow_flag   <= overflow_flag_next;
    end
  end

endmodule

### rtl/core/rtop_queue.sv
// ----------------------------------------------------------------------------
// rtop_queue
// Two-entry job queue between the parser front end and the evaluator.
// ----------------------------------------------------------------------------
module rtop_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rtop_pkg::job_t push_job,
  output logic           full,
  output logic           head_valid,
  output rtop_pkg::job_t head_job,
  input  logic           pop
);

  rtop_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not advance on push");

endmodule

### rtl/core/rtop_back.sv
// ----------------------------------------------------------------------------
// rtop_back
// Evaluates one job: shared multiplier for the unit scaling, bit-serial
// divider for the decimal fraction, then sum, clamp and output register.
// ----------------------------------------------------------------------------
module rtop_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                head_valid,
  input  rtop_pkg::job_t                      head_job,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rtop_pkg::VAL_W-1:0]   time_value,
  output logic [rtop_pkg::STATUS_W-1:0]       status,
  output logic [rtop_pkg::KIND_W-1:0]         kind
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_INT  = 3'd1;
  localparam logic [2:0] S_MUL_FRAC = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_SUM      = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam int MAG_W = 60;
  localparam int R_W   = 61;
  localparam int CNT_W = 6;

  localparam logic [MAG_W-1:0] MAG_CAP = {2'b01, 58'b0};
  localparam logic signed [R_W-1:0] R_MAX = {4'b0000, {57{1'b1}}};
  localparam logic signed [R_W-1:0] R_MIN = {4'b1111, 57'b0};

  logic [2:0]                          state;
  rtop_pkg::job_t                      job;
  logic [rtop_pkg::PROD_W-1:0]         ip;
  logic [rtop_pkg::DIVS_W-1:0]         divisor;
  logic [rtop_pkg::DIVS_W-1:0]         rem;
  logic [rtop_pkg::DIVD_W-1:0]         quo;
  logic [CNT_W-1:0]                    div_cnt;
  logic signed [rtop_pkg::VAL_W-1:0]   res_value;
  logic [rtop_pkg::STATUS_W-1:0]       res_status;
  logic [rtop_pkg::KIND_W-1:0]         res_kind;

  logic [rtop_pkg::SCALE_W-1:0]        scale;
  logic [rtop_pkg::INT_BITS-1:0]       mul_a;
  logic [rtop_pkg::PROD_W-1:0]         mul_p;
  logic [rtop_pkg::DIVS_W-1:0]         div_sel;
  logic [rtop_pkg::DIVD_W-1:0]         dividend;
  logic [rtop_pkg::DIVS_W:0]           trial;
  logic [MAG_W-1:0]                    mag, mag_sat;
  logic [R_W-1:0]                      base, r;
  logic                                load_out;

  assign scale = rtop_pkg::unit_scale(job.unit);
  assign mul_a = (state == S_MUL_INT) ? job.int_acc
               : {{(rtop_pkg::INT_BITS-rtop_pkg::FACC_W){1'b0}}, job.frac_acc};
  assign mul_p = {{rtop_pkg::SCALE_W{1'b0}}, mul_a} * {{rtop_pkg::INT_BITS{1'b0}}, scale};

  // Fraction scaled by 2^FRAC_BITS, biased by half the divisor for rounding
  assign div_sel  = rtop_pkg::pow10(job.frac_digits);
  assign dividend = {mul_p[rtop_pkg::DIVD_W-rtop_pkg::FRAC_BITS-2:0], {rtop_pkg::FRAC_BITS{1'b0}},
                     1'b0}[rtop_pkg::DIVD_W:1]
                    + {{(rtop_pkg::DIVD_W-rtop_pkg::DIVS_W+1){1'b0}},
                       div_sel[rtop_pkg::DIVS_W-1:1]};

  assign trial = {rem, quo[rtop_pkg::DIVD_W-1]} - {1'b0, divisor};

  assign mag = {3'b0, ip, {rtop_pkg::FRAC_BITS{1'b0}}} + {6'b0, quo};
  assign mag_sat = (mag > MAG_CAP) ? MAG_CAP : mag;
  assign base = {13'b0, job.now, {rtop_pkg::FRAC_BITS{1'b0}}};
  assign r = job.minus ? (base - {1'b0, mag_sat}) : (base + {1'b0, mag_sat});

  assign pop      = (state == S_IDLE) && head_valid;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            state <= (head_job.op == rtop_pkg::OP_REL) ? S_MUL_INT : S_DONE;
          end
        end
        S_MUL_INT:  state <= S_MUL_FRAC;
        S_MUL_FRAC: state <= S_DIV;
        S_DIV: begin
          if (div_cnt == CNT_W'(1)) state <= S_SUM;
        end
        S_SUM: state <= S_DONE;
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        job <= head_job;
        case (head_job.op)
          rtop_pkg::OP_NOW: begin
            res_value  <= {10'b0, head_job.now, {rtop_pkg::FRAC_BITS{1'b0}}};
            res_status <= rtop_pkg::ST_OK;
            res_kind   <= rtop_pkg::KIND_NOW;
          end
          rtop_pkg::OP_EPOCH: begin
            res_value  <= {26'b0, head_job.int_acc, {rtop_pkg::FRAC_BITS{1'b0}}};
            res_status <= head_job.overflow ? rtop_pkg::ST_SAT : rtop_pkg::ST_OK;
            res_kind   <= rtop_pkg::KIND_EPOCH;
          end
          default: begin
            res_value  <= '0;
            res_status <= rtop_pkg::ST_SYNTAX;
            res_kind   <= rtop_pkg::KIND_NOW;
          end
        endcase
      end
      S_MUL_INT: ip <= mul_p;
      S_MUL_FRAC: begin
        divisor <= div_sel;
        rem     <= '0;
        quo     <= dividend;
        div_cnt <= CNT_W'(rtop_pkg::DIVD_W);
      end
      S_DIV: begin
        if (!trial[rtop_pkg::DIVS_W]) begin
          rem <= trial[rtop_pkg::DIVS_W-1:0];
        end else begin
          rem <= {rem[rtop_pkg::DIVS_W-2:0], quo[rtop_pkg::DIVD_W-1]};
        end
        quo     <= {quo[rtop_pkg::DIVD_W-2:0], !trial[rtop_pkg::DIVS_W]};
        div_cnt <= div_cnt - CNT_W'(1);
      end
      S_SUM: begin
        res_kind <= rtop_pkg::KIND_REL;
        if ($signed(r) > R_MAX) begin
          res_value  <= R_MAX[rtop_pkg::VAL_W-1:0];
          res_status <= rtop_pkg::ST_SAT;
        end else if ($signed(r) < R_MIN) begin
          res_value  <= R_MIN[rtop_pkg::VAL_W-1:0];
          res_status <= rtop_pkg::ST_SAT;
        end else begin
          res_value  <= r[rtop_pkg::VAL_W-1:0];
          res_status <= job.overflow ? rtop_pkg::ST_SAT : rtop_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      time_value <= res_value;
      status     <= res_status;
      kind       <= res_kind;
    end
  end

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt != '0))
    else $error("divider running with zero step count");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("divider remainder not below divisor");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_MUL_INT || state == S_DONE))
    else $error("job taken without starting evaluation");

endmodule

### rtl/core/relative_time_offset_parser_unit.sv
// ----------------------------------------------------------------------------
// relative_time_offset_parser_unit
// Parses an expiry string ("now", an epoch number, or a signed offset with
// optional fraction and unit) and gives the resulting time in fixed point.
// ----------------------------------------------------------------------------
//
// Channel   Handshake               Payload
// input     in_valid / in_ready     char_code, is_end, now_seconds
// output    out_valid / out_ready   time_value, status, kind
//
// Character transactions are absorbed by the front end; they give no result.
// An end transaction pushes one job into a two-entry queue. A "now", epoch or
// error job goes from the evaluator's idle state to its final state and then
// into the output register; a relative job first passes the shared multiplier
// (two passes), the bit-serial fraction divider (54 steps) and the sum and
// clamp. in_ready drops only while the queue holds two jobs; a stalled output
// holds the evaluator in its final state. Reset clears all parse state, the
// queue and the output valid; no clearing pass is needed.
//
module relative_time_offset_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rtop_pkg::CHAR_W-1:0]         char_code,
  input  logic                                is_end,
  input  logic [rtop_pkg::NOW_W-1:0]          now_seconds,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rtop_pkg::VAL_W-1:0]   time_value,
  output logic [rtop_pkg::STATUS_W-1:0]       status,
  output logic [rtop_pkg::KIND_W-1:0]         kind
);

  logic           q_full;
  logic           push;
  rtop_pkg::job_t push_job;
  logic           head_valid;
  rtop_pkg::job_t head_job;
  logic           pop;

  // Front end: accumulate characters, classify on the end transaction
  rtop_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .is_end      (is_end),
    .now_seconds (now_seconds),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  // Decouple the parser from the evaluator
  rtop_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // Back end: scale, divide, sum, clamp and hold the result
  rtop_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .time_value (time_value),
    .status     (status),
    .kind       (kind)
  );

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Relative time offset parser testbench
// Streams expiry strings one character per transaction into the parser, each
// closed by an end transaction that carries the current time. A scoreboard
// tracks the parse state on its own, computes the time, status and kind of
// every end transaction and matches them against the result channel. Both
// channels idle at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import rtop_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 800;     // long output hold-off
  localparam int HOLD_AFTER   = 40;      // results seen before the hold-off

  // Parse progress and sign of the string seen so far
  localparam logic [1:0] PH_NONE  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_NUM   = 2'd2;
  localparam logic [1:0] PH_UNIT  = 2'd3;
  localparam logic [1:0] SG_NONE  = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_MINUS = 2'd2;
  localparam logic [2:0] NOW_FULL = 3'd3;  // all of "now" matched
  localparam logic [2:0] NOW_MISS = 3'd4;  // can no longer be "now"

  localparam logic [63:0]       INT_LIMIT = (64'd1 << INT_BITS) - 64'd1;
  localparam logic [63:0]       MAG_CAP   = 64'd1 << 58;
  localparam longint            OUT_MAX   = 64'sh01FF_FFFF_FFFF_FFFF;
  localparam longint            OUT_MIN   = -OUT_MAX - 64'sd1;
  localparam logic [NOW_W-1:0]  NOW_MAX   = '1;

  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic [STATUS_W-1:0] status;
    logic [KIND_W-1:0]   kind;
  } time_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the parse state and queues the expected time results
  // --------------------------------------------------------------------------
  class expiry_scoreboard;
    logic [1:0]        phase;
    logic [1:0]        sign_mode;
    logic              in_fraction;
    logic [INT_BITS-1:0] int_acc;
    logic [FACC_W-1:0] frac_acc;
    logic [FDIG_W-1:0] frac_digits;
    logic [UNIT_W-1:0] unit_sel;
    logic [2:0]        now_match;
    logic              syntax_err;
    logic              int_sat;
    time_result_t      expected_times[$];
    int                errors;

    function new();
      errors = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase       = PH_NONE;
      sign_mode   = SG_NONE;
      in_fraction = 1'b0;
      int_acc     = '0;
      frac_acc    = '0;
      frac_digits = '0;
      unit_sel    = UNIT_S;
      now_match   = '0;
      syntax_err  = 1'b0;
      int_sat     = 1'b0;
    endfunction

    function int pending();
      return expected_times.size();
    endfunction

    // Advance the parse on a character, or on an end transaction compute the
    // result and queue it.
    function void absorb_transaction(logic [CHAR_W-1:0] c, logic last,
                                     logic [NOW_W-1:0] now_s);
      logic [3:0]        digit;
      logic              word_hit;
      logic              unit_hit;
      logic [UNIT_W-1:0] unit_code;
      logic [63:0]       acc, scale, div, ip, fp, mag;
      longint            base, r;
      time_result_t      res;

      if (!last) begin
        // The "now" match runs even after a syntax error
        word_hit = (now_match == 3'd0 && c == "n") ||
                   (now_match == 3'd1 && c == "o") ||
                   (now_match == 3'd2 && c == "w");
        now_match = word_hit ? now_match + 3'd1 : NOW_MISS;
        if (syntax_err)
          return;

        unit_hit = 1'b1;
        unit_code = UNIT_S;
        case (c)
          "s": unit_code = UNIT_S;
          "m": unit_code = UNIT_MIN;
          "h": unit_code = UNIT_H;
          "d": unit_code = UNIT_D;
          "M": unit_code = UNIT_MON;
          "y": unit_code = UNIT_Y;
          default: unit_hit = 1'b0;
        endcase
        digit = 4'(c - 8'h30);

        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
          if (phase != PH_NONE)
            syntax_err = 1'b1;
        end else if (c == "+" || c == "-") begin
          if (phase != PH_NONE) begin
            syntax_err = 1'b1;
          end else begin
            phase = PH_SIGN;
            sign_mode = (c == "+") ? SG_PLUS : SG_MINUS;
          end
        end else if (c >= "0" && c <= "9") begin
          if (phase == PH_UNIT) begin
            syntax_err = 1'b1;
          end else begin
            phase = PH_NUM;
            if (!in_fraction) begin
              acc = 64'(int_acc) * 64'd10 + 64'(digit);
              if (acc > INT_LIMIT) begin
                acc = INT_LIMIT;
                int_sat = 1'b1;
              end
              int_acc = acc[INT_BITS-1:0];
            end else if (frac_digits < FRAC_DIGITS) begin
              // drop digits past the kept precision
              frac_acc = FACC_W'(frac_acc * 10 + digit);
              frac_digits = frac_digits + 1'b1;
            end
          end
        end else if (c == ".") begin
          if (phase == PH_UNIT || in_fraction) begin
            syntax_err = 1'b1;
          end else begin
            phase = PH_NUM;
            in_fraction = 1'b1;
          end
        end else if (unit_hit) begin
          if (phase == PH_UNIT) begin
            syntax_err = 1'b1;
          end else begin
            phase = PH_UNIT;
            unit_sel = unit_code;
          end
        end else begin
          syntax_err = 1'b1;
        end
        return;
      end

      base = $signed(64'(now_s) << FRAC_BITS);
      res.value  = '0;
      res.status = ST_OK;
      res.kind   = KIND_NOW;

      if (now_match == NOW_FULL) begin
        res.value = base[VAL_W-1:0];
      end else if (syntax_err || phase < PH_NUM) begin
        res.status = ST_SYNTAX;
      end else if (phase == PH_NUM && sign_mode == SG_NONE) begin
        // Bare epoch number: the fraction is ignored
        acc = 64'(int_acc) << FRAC_BITS;
        res.kind   = KIND_EPOCH;
        res.value  = acc[VAL_W-1:0];
        res.status = int_sat ? ST_SAT : ST_OK;
      end else begin
        case (unit_sel)
          UNIT_MIN: scale = 64'd60;
          UNIT_H:   scale = 64'd3600;
          UNIT_D:   scale = 64'd86400;
          UNIT_MON: scale = 64'd86400 * 64'd30;
          UNIT_Y:   scale = 64'd86400 * 64'd365;
          default:  scale = 64'd1;
        endcase
        div = 64'd1;
        repeat (frac_digits) div = div * 64'd10;
        // Round the magnitude once, halves away from zero, then apply sign
        ip = 64'(int_acc) * scale;
        fp = (64'(frac_acc) * scale) << FRAC_BITS;
        fp = (fp + div / 64'd2) / div;
        if (ip >= (MAG_CAP >> FRAC_BITS))
          mag = MAG_CAP;
        else
          mag = (ip << FRAC_BITS) + fp;
        if (mag > MAG_CAP)
          mag = MAG_CAP;
        r = (sign_mode == SG_MINUS) ? base - $signed(mag) : base + $signed(mag);
        res.kind   = KIND_REL;
        res.status = int_sat ? ST_SAT : ST_OK;
        if (r > OUT_MAX) begin
          r = OUT_MAX;
          res.status = ST_SAT;
        end
        if (r < OUT_MIN) begin
          r = OUT_MIN;
          res.status = ST_SAT;
        end
        res.value = r[VAL_W-1:0];
      end

      expected_times.push_back(res);
      clear_parse();
    endfunction

    // Match one result transaction against the oldest expected time
    function void check_time_result(logic [VAL_W-1:0] v, logic [STATUS_W-1:0] st,
                                    logic [KIND_W-1:0] kd);
      time_result_t exp_res;
      if (expected_times.size() == 0) begin
        $display("%0t: result with none expected: time_value %0d status %0d kind %0d",
                 $time, $signed(v), st, kd);
        errors++;
        return;
      end
      exp_res = expected_times.pop_front();
      if (v !== exp_res.value) begin
        $display("%0t: time_value mismatch: expected %0d actual %0d",
                 $time, $signed(exp_res.value), $signed(v));
        errors++;
      end
      if (st !== exp_res.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, exp_res.status, st);
        errors++;
      end
      if (kd !== exp_res.kind) begin
        $display("%0t: kind mismatch: expected %0d actual %0d",
                 $time, exp_res.kind, kd);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CHAR_W-1:0]          char_code = '0;
  logic                       is_end = 1'b0;
  logic [NOW_W-1:0]           now_seconds = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [VAL_W-1:0]    time_value;
  logic [STATUS_W-1:0]        status;
  logic [KIND_W-1:0]          kind;

  expiry_scoreboard sb;
  int               items_sent = 0;
  logic [7:0]       text_q[$];   // characters of the next expiry string

  always #6 clk = ~clk;

  relative_time_offset_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .char_code   (char_code),
    .is_end      (is_end),
    .now_seconds (now_seconds),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .time_value  (time_value),
    .status      (status),
    .kind        (kind)
  );

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones; every 400
  // transactions open with a stretch of no gaps at all.
  function automatic int pick_gap();
    int r;
    if (items_sent % 400 < 80)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  function automatic logic [NOW_W-1:0] rand_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)
      return '0;
    else if (r < 10)
      return NOW_MAX;
    else
      return {8'($urandom), 32'($urandom)};
  endfunction

  // Offer one transaction and hold it until the block takes it. Call at a
  // rising edge; returns at the edge that accepted the transaction.
  task automatic send_byte(logic [CHAR_W-1:0] c, logic last, logic [NOW_W-1:0] now_s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    char_code   <= c;
    is_end      <= last;
    now_seconds <= now_s;
    do @(posedge clk); while (!in_ready);
    sb.absorb_transaction(c, last, now_s);
    items_sent++;
  endtask

  // Send the characters held in text_q, then the end transaction. The
  // ignored fields carry random values so every input bit toggles.
  task automatic send_expiry(logic [NOW_W-1:0] now_s);
    foreach (text_q[i])
      send_byte(text_q[i], 1'b0, {8'($urandom), 32'($urandom)});
    send_byte(8'($urandom), 1'b1, now_s);
  endtask

  task automatic send_string(string s, logic [NOW_W-1:0] now_s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++)
      text_q.push_back(s[i]);
    send_expiry(now_s);
  endtask

  // Build a random expiry string: mostly well formed with random content,
  // some with one byte corrupted, a few pure noise or the word now.
  task automatic build_random_expiry();
    logic [7:0] unit_chars[6];
    logic [7:0] space_chars[6];
    int r, n;
    unit_chars  = '{"s", "m", "h", "d", "M", "y"};
    space_chars = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
    text_q.delete();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      text_q = '{"n", "o", "w"};
      return;
    end
    if (r >= 94) begin
      n = $urandom_range(1, 6);
      repeat (n) text_q.push_back(8'($urandom));
      return;
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) text_q.push_back(space_chars[$urandom_range(0, 5)]);
    case ($urandom_range(0, 3))
      1: text_q.push_back("+");
      2: text_q.push_back("-");
      default: ;
    endcase
    // Long integers push the accumulator into saturation
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 4);
    repeat (n) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    if ($urandom_range(0, 2) == 0) begin
      text_q.push_back(".");
      n = $urandom_range(0, 8);
      repeat (n) text_q.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) != 0)
      text_q.push_back(unit_chars[$urandom_range(0, 5)]);
    if (r >= 82 && text_q.size() > 0)
      text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The word now, and near misses of it
    send_string("now", NOW_MAX);
    send_string("now", '0);
    send_string("no", 40'd1000);
    send_string("nowx", 40'd1000);
    send_string("", 40'd77);
    // Leading white space of every kind before a signed offset
    send_string("   +5h", 40'd1_700_000_000);
    text_q = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, "-", "7", "d"};
    send_expiry(40'd1_700_000_000);
    // Epoch numbers: largest exact, saturated, fraction dropped
    send_string("16777215", NOW_MAX);
    send_string("99999999999", 40'd5);
    send_string("123.456", 40'd5);
    // Extreme offsets, fraction past the kept digits, rounding
    send_string("-99999999y", '0);
    send_string("+99999999y", NOW_MAX);
    send_string("+1.1234567M", 40'd123456);
    send_string("-0.999999s", 40'd3);
    send_string("2.5m", 40'd60);
    // Lone dot and unit without digits
    send_string(".", 40'd9);
    send_string("h", 40'd42);
    send_string("-d", 40'd42);
    // Syntax errors
    send_string("+", 40'd1);
    send_string("++1", 40'd1);
    send_string("1+", 40'd1);
    send_string("1..2", 40'd1);
    send_string("5hh", 40'd1);
    send_string("5h1", 40'd1);
    send_string("5 ", 40'd1);
    text_q = '{8'd200, "5"};
    send_expiry(40'd1);

    while (items_sent < ITEM_TARGET) begin
      build_random_expiry();
      send_expiry(rand_now());
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then let the block settle
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS relative_time_offset_parser_unit");
    else
      $display("FAIL relative_time_offset_parser_unit");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: check accepted results and drive out_ready. Stall at random,
  // run calm stretches with no stalls, and once hold off long enough that the
  // job queue fills and in_ready drops while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int  cycle_no;
    int  stall_left;
    int  results_seen;
    int  r;
    bit  held;
    cycle_no = 0;
    stall_left = 0;
    results_seen = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (!rst && out_valid && out_ready) begin
        sb.check_time_result(time_value, status, kind);
        results_seen++;
      end
      if (!held && results_seen == HOLD_AFTER) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (cycle_no % 500 < 100) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          // hold low this cycle and count the rest of the stall
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Watchdog: end a hung run
  initial begin : watchdog
    #12_000_000;
    $display("FAIL relative_time_offset_parser_unit");
    $finish;
  end

endmodule

### filelist.f
rtl/core/rtop_pkg.sv
rtl/core/rtop_front.sv
rtl/core/rtop_queue.sv
rtl/core/rtop_back.sv
rtl/core/relative_time_offset_parser_unit.sv
dv/testbench.sv
